// File: rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the LED segment animation block.
// They expect a clock named clk and an active-low reset named rst_n in scope.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSMF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSMF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: rtl/lsmf_pkg.sv
// ============================================================================
// LED segment motion and fade package
// Widths, register indexes, controller states and command types.
// ============================================================================
package lsmf_pkg;

    localparam int FRAME_RATE_DEF = 60;
    localparam int MAX_LEDS       = 1024;
    localparam int MS_PER_S       = 1000;

    localparam int IDX_W      = 10;
    localparam int POS_W      = 18;
    localparam int EXT_W      = 22;
    localparam int STEP_W     = 17;
    localparam int ELAPSED_W  = 48;
    localparam int MS_W       = 16;
    localparam int BRIGHT_W   = 9;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int QUOT_W     = 24;
    localparam int DIV_CNT_W  = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_LONG  = DIV_CNT_W'(ELAPSED_W / 2);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SHORT = DIV_CNT_W'(QUOT_W / 2);

    localparam int LED_LAST = (MAX_LEDS > 1024) ? 1023 : MAX_LEDS - 1;
    localparam logic [IDX_W-1:0] LED_MAX_IDX = IDX_W'(LED_LAST);

    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = BRIGHT_W'(256);
    localparam logic [BRIGHT_W-1:0] BRIGHT_OFF  = '0;

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOVE_A,
        ST_MOVE_B,
        ST_MOVE_C,
        ST_PHASE,
        ST_PHASE_WAIT,
        ST_FADE,
        ST_FADE_WAIT,
        ST_OUT
    } lsmf_state_t;

    typedef struct packed {
        logic accept;
        logic move_a;
        logic move_b;
        logic move_c;
        logic phase_start;
        logic phase_load;
        logic fade_eval;
        logic bright_load;
        logic out_load;
    } lsmf_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic period_zero;
        logic fade_div;
    } lsmf_status_t;

    function automatic logic [IDX_W-1:0] sat_idx(input logic [IDX_W-1:0] v);
        sat_idx = (v > LED_MAX_IDX) ? LED_MAX_IDX : v;
    endfunction

endpackage

// File: rtl/lsmf_div.sv
// ============================================================================
// Radix-4 restoring divider
// Divides a 48-bit dividend by a 16-bit divisor, two quotient bits per cycle.
// Short mode divides a 24-bit value placed in the upper half of the dividend.
// ============================================================================
module lsmf_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 short_mode,
    input  logic [lsmf_pkg::ELAPSED_W-1:0]       dividend,
    input  logic [lsmf_pkg::MS_W-1:0]            divisor,
    output logic                                 busy,
    output logic [lsmf_pkg::QUOT_W-1:0]          quotient,
    output logic [lsmf_pkg::MS_W-1:0]            remainder
);

    logic                                 busy_reg;
    logic [lsmf_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [lsmf_pkg::ELAPSED_W-1:0]       dvd_reg;
    logic [lsmf_pkg::MS_W-1:0]            dvs_reg;
    logic [lsmf_pkg::MS_W-1:0]            rem_reg;

    logic [lsmf_pkg::MS_W:0]              r1;
    logic [lsmf_pkg::MS_W:0]              r1s;
    logic [lsmf_pkg::MS_W:0]              r2;
    logic [lsmf_pkg::MS_W:0]              r2s;
    logic                                 ge1;
    logic                                 ge2;

    always_comb
    begin
        r1  = {rem_reg, dvd_reg[lsmf_pkg::ELAPSED_W-1]};
        ge1 = (r1 >= {1'b0, dvs_reg});
        r1s = ge1 ? (r1 - {1'b0, dvs_reg}) : r1;
        r2  = {r1s[lsmf_pkg::MS_W-1:0], dvd_reg[lsmf_pkg::ELAPSED_W-2]};
        ge2 = (r2 >= {1'b0, dvs_reg});
        r2s = ge2 ? (r2 - {1'b0, dvs_reg}) : r2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= short_mode ? lsmf_pkg::DIV_STEPS_SHORT : lsmf_pkg::DIV_STEPS_LONG;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_ONE)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    localparam logic [lsmf_pkg::DIV_CNT_W-1:0] DIV_CNT_ONE = lsmf_pkg::DIV_CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[lsmf_pkg::ELAPSED_W-3:0], ge1, ge2};
            rem_reg <= r2s[lsmf_pkg::MS_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = dvd_reg[lsmf_pkg::QUOT_W-1:0];
    assign remainder = rem_reg;

endmodule

// File: rtl/lsmf_ctrl.sv
// ============================================================================
// LED segment animation controller
// Sequences the move, phase and fade steps of one transaction and holds the
// output valid flag.
// ============================================================================
module lsmf_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   func,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lsmf_pkg::lsmf_cmd_t    cmd,
    input  lsmf_pkg::lsmf_status_t status
);

    lsmf_pkg::lsmf_state_t state_reg;
    lsmf_pkg::lsmf_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsmf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            lsmf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (func == lsmf_pkg::FUNC_RESTART) ? lsmf_pkg::ST_PHASE
                                                                  : lsmf_pkg::ST_MOVE_A;
                end
            end
            lsmf_pkg::ST_MOVE_A:
            begin
                cmd.move_a = 1'b1;
                state_next = lsmf_pkg::ST_MOVE_B;
            end
            lsmf_pkg::ST_MOVE_B:
            begin
                cmd.move_b = 1'b1;
                state_next = lsmf_pkg::ST_MOVE_C;
            end
            lsmf_pkg::ST_MOVE_C:
            begin
                cmd.move_c = 1'b1;
                state_next = lsmf_pkg::ST_PHASE;
            end
            lsmf_pkg::ST_PHASE:
            begin
                cmd.phase_start = 1'b1;
                state_next = status.period_zero ? lsmf_pkg::ST_FADE : lsmf_pkg::ST_PHASE_WAIT;
            end
            lsmf_pkg::ST_PHASE_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.phase_load = 1'b1;
                    state_next     = lsmf_pkg::ST_FADE;
                end
            end
            lsmf_pkg::ST_FADE:
            begin
                cmd.fade_eval = 1'b1;
                state_next = status.fade_div ? lsmf_pkg::ST_FADE_WAIT : lsmf_pkg::ST_OUT;
            end
            lsmf_pkg::ST_FADE_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.bright_load = 1'b1;
                    state_next      = lsmf_pkg::ST_OUT;
                end
            end
            lsmf_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lsmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/lsmf_datapath.sv
// ============================================================================
// LED segment animation datapath
// Configuration registers, position and time state, the move arithmetic,
// the fade evaluation and the output registers, around a shared divider.
// ============================================================================
module lsmf_datapath
#(
    parameter int FRAME_RATE = lsmf_pkg::FRAME_RATE_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lsmf_pkg::lsmf_cmd_t                 cmd,
    output lsmf_pkg::lsmf_status_t              status,
    input  logic                                cfg_we,
    input  logic [lsmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsmf_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                func,
    input  logic [lsmf_pkg::IDX_W-1:0]          start_position,
    output logic [lsmf_pkg::POS_W-1:0]          position_q8,
    output logic                                moving_up,
    output logic [lsmf_pkg::BRIGHT_W-1:0]       brightness_q8,
    output logic [lsmf_pkg::MS_W-1:0]           cycle_phase_ms
);

    localparam int MS_QUOT = lsmf_pkg::MS_PER_S / FRAME_RATE;
    localparam int MS_REM  = lsmf_pkg::MS_PER_S % FRAME_RATE;
    localparam int REM_W   = $clog2(FRAME_RATE + 1);
    localparam int SUM_W   = $clog2(2 * FRAME_RATE + 1);
    localparam int EXT_W   = lsmf_pkg::EXT_W;
    localparam int IDX_W   = lsmf_pkg::IDX_W;
    localparam int POS_W   = lsmf_pkg::POS_W;
    localparam int MS_W    = lsmf_pkg::MS_W;

    localparam logic signed [EXT_W-1:0] LED_Q8_ONE = EXT_W'(256);

    logic signed [lsmf_pkg::STEP_W-1:0]   step_reg;
    logic [IDX_W-1:0]                     range_low_reg;
    logic [IDX_W-1:0]                     range_high_reg;
    logic [IDX_W-1:0]                     seg_len_reg;
    logic [1:0]                           mode_reg;
    logic [lsmf_pkg::CFG_W-1:0]           fade_in_reg;
    logic [lsmf_pkg::CFG_W-1:0]           fade_out_reg;
    logic [MS_W-1:0]                      period_reg;

    logic [POS_W-1:0]                     pos_reg;
    logic                                 dir_reg;
    logic [lsmf_pkg::ELAPSED_W-1:0]       elapsed_reg;
    logic [REM_W-1:0]                     ms_rem_reg;

    logic signed [EXT_W-1:0]              np_reg;
    logic signed [EXT_W-1:0]              top_reg;
    logic [MS_W-1:0]                      phase_reg;
    logic [lsmf_pkg::BRIGHT_W-1:0]        bright_reg;

    logic [POS_W-1:0]                     pos_out_reg;
    logic                                 dir_out_reg;
    logic [lsmf_pkg::BRIGHT_W-1:0]        bright_out_reg;
    logic [MS_W-1:0]                      phase_out_reg;

    // Time advance.
    logic [SUM_W-1:0]                     rem_sum;
    logic                                 rem_wrap;
    logic [REM_W-1:0]                     ms_rem_next;
    logic [lsmf_pkg::ELAPSED_W-1:0]       elapsed_next;

    // Range bounds.
    logic [IDX_W-1:0]                     sat_a;
    logic [IDX_W-1:0]                     sat_b;
    logic [IDX_W-1:0]                     lo_idx;
    logic [IDX_W-1:0]                     hi_idx;
    logic signed [EXT_W-1:0]              lo256;
    logic signed [EXT_W-1:0]              hi256;
    logic signed [EXT_W-1:0]              maxp;
    logic signed [EXT_W-1:0]              len_off;
    logic [IDX_W+1:0]                     hi_len_diff;
    logic [IDX_W+1:0]                     len_less_one;

    // Clamp on a range write.
    logic [IDX_W-1:0]                     wr_low;
    logic [IDX_W-1:0]                     wr_high;
    logic [IDX_W-1:0]                     wr_a;
    logic [IDX_W-1:0]                     wr_b;
    logic [POS_W-1:0]                     wr_lo256;
    logic [POS_W-1:0]                     wr_hi256;
    logic [POS_W-1:0]                     pos_clamped;

    // Move steps.
    logic [lsmf_pkg::STEP_W-1:0]          mag;
    logic signed [EXT_W-1:0]              pos_ext;
    logic signed [EXT_W-1:0]              mag_ext;
    logic signed [EXT_W-1:0]              step_np;
    logic signed [EXT_W-1:0]              edge_np;
    logic                                 edge_dir;
    logic signed [EXT_W-1:0]              clamp_hi;
    logic signed [EXT_W-1:0]              clamp_np;

    // Fade evaluation.
    logic [MS_W-1:0]                      in_start;
    logic [MS_W-1:0]                      in_end;
    logic [MS_W-1:0]                      out_start;
    logic [MS_W-1:0]                      out_end;
    logic                                 fade_active;
    logic                                 fade_div_raw;
    logic [MS_W-1:0]                      fade_num;
    logic [MS_W-1:0]                      fade_den;
    logic [lsmf_pkg::BRIGHT_W-1:0]        fade_const;

    // Divider connection.
    logic                                 div_start;
    logic [lsmf_pkg::ELAPSED_W-1:0]       div_dividend;
    logic [MS_W-1:0]                      div_divisor;
    logic                                 div_busy;
    logic [lsmf_pkg::QUOT_W-1:0]          div_quot;
    logic [MS_W-1:0]                      div_rem;

    always_comb
    begin
        rem_sum      = SUM_W'(ms_rem_reg) + SUM_W'(MS_REM);
        rem_wrap     = (rem_sum >= SUM_W'(FRAME_RATE));
        ms_rem_next  = rem_wrap ? REM_W'(rem_sum - SUM_W'(FRAME_RATE)) : REM_W'(rem_sum);
        elapsed_next = elapsed_reg + (rem_wrap ? lsmf_pkg::ELAPSED_W'(MS_QUOT + 1)
                                               : lsmf_pkg::ELAPSED_W'(MS_QUOT));
    end

    always_comb
    begin
        sat_a        = lsmf_pkg::sat_idx(range_low_reg);
        sat_b        = lsmf_pkg::sat_idx(range_high_reg);
        lo_idx       = (sat_a < sat_b) ? sat_a : sat_b;
        hi_idx       = (sat_a < sat_b) ? sat_b : sat_a;
        lo256        = {{(EXT_W-POS_W){1'b0}}, lo_idx, 8'b0};
        hi256        = {{(EXT_W-POS_W){1'b0}}, hi_idx, 8'b0};
        hi_len_diff  = {2'b0, hi_idx} - {2'b0, seg_len_reg} + 12'd1;
        len_less_one = {2'b0, seg_len_reg} - 12'd1;
        maxp         = {{(EXT_W-20){hi_len_diff[IDX_W+1]}}, hi_len_diff, 8'b0};
        len_off      = {{(EXT_W-20){len_less_one[IDX_W+1]}}, len_less_one, 8'b0};
    end

    always_comb
    begin
        wr_low      = (cfg_index == lsmf_pkg::REG_LOW) ? cfg_data[IDX_W-1:0] : range_low_reg;
        wr_high     = (cfg_index == lsmf_pkg::REG_HIGH) ? cfg_data[IDX_W-1:0] : range_high_reg;
        wr_a        = lsmf_pkg::sat_idx(wr_low);
        wr_b        = lsmf_pkg::sat_idx(wr_high);
        wr_lo256    = {((wr_a < wr_b) ? wr_a : wr_b), 8'b0};
        wr_hi256    = {((wr_a < wr_b) ? wr_b : wr_a), 8'b0};
        if (pos_reg < wr_lo256)
        begin
            pos_clamped = wr_lo256;
        end
        else if (pos_reg > wr_hi256)
        begin
            pos_clamped = wr_hi256;
        end
        else
        begin
            pos_clamped = pos_reg;
        end
    end

    always_comb
    begin
        mag     = step_reg[lsmf_pkg::STEP_W-1] ? $unsigned(-step_reg) : $unsigned(step_reg);
        pos_ext = {{(EXT_W-POS_W){1'b0}}, pos_reg};
        mag_ext = {{(EXT_W-lsmf_pkg::STEP_W){1'b0}}, mag};
        step_np = dir_reg ? (pos_ext + mag_ext) : (pos_ext - mag_ext);
    end

    always_comb
    begin
        edge_np  = np_reg;
        edge_dir = dir_reg;
        if (mode_reg[0])
        begin
            if (np_reg < lo256)
            begin
                edge_np  = (lo256 <<< 1) - np_reg;
                edge_dir = 1'b1;
            end
            else if (top_reg > hi256)
            begin
                edge_np  = maxp + hi256 - top_reg;
                edge_dir = 1'b0;
            end
        end
        else
        begin
            if (np_reg < lo256)
            begin
                edge_np = hi256 + LED_Q8_ONE - lo256 + np_reg;
            end
            else if (top_reg > hi256)
            begin
                edge_np = lo256 + top_reg - hi256 - LED_Q8_ONE;
            end
        end
    end

    always_comb
    begin
        clamp_hi = (np_reg > maxp) ? maxp : np_reg;
        clamp_np = (clamp_hi < lo256) ? lo256 : clamp_hi;
    end

    always_comb
    begin
        in_start     = fade_in_reg[MS_W-1:0];
        in_end       = fade_in_reg[2*MS_W-1:MS_W];
        out_start    = fade_out_reg[MS_W-1:0];
        out_end      = fade_out_reg[2*MS_W-1:MS_W];
        fade_active  = (period_reg != '0) && mode_reg[1];
        fade_div_raw = 1'b0;
        fade_num     = '0;
        fade_den     = '0;
        fade_const   = lsmf_pkg::BRIGHT_OFF;
        if (phase_reg < in_start)
        begin
            fade_const = lsmf_pkg::BRIGHT_OFF;
        end
        else if (phase_reg < in_end)
        begin
            fade_div_raw = 1'b1;
            fade_num     = phase_reg - in_start;
            fade_den     = in_end - in_start;
        end
        else if (phase_reg < out_start)
        begin
            fade_const = lsmf_pkg::BRIGHT_FULL;
        end
        else if (phase_reg < out_end)
        begin
            fade_div_raw = 1'b1;
            fade_num     = out_end - phase_reg;
            fade_den     = out_end - out_start;
        end
    end

    assign status.div_busy    = div_busy;
    assign status.period_zero = (period_reg == '0);
    assign status.fade_div    = fade_active && fade_div_raw;

    always_comb
    begin
        div_start    = (cmd.phase_start && !status.period_zero)
                       || (cmd.fade_eval && status.fade_div);
        div_dividend = cmd.fade_eval ? {fade_num, 8'b0, {lsmf_pkg::QUOT_W{1'b0}}} : elapsed_reg;
        div_divisor  = cmd.fade_eval ? fade_den : period_reg;
    end

    lsmf_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .short_mode (cmd.fade_eval),
        .dividend   (div_dividend),
        .divisor    (div_divisor),
        .busy       (div_busy),
        .quotient   (div_quot),
        .remainder  (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= '0;
            range_low_reg  <= '0;
            range_high_reg <= IDX_W'(1023);
            seg_len_reg    <= IDX_W'(1);
            mode_reg       <= '0;
            fade_in_reg    <= '0;
            fade_out_reg   <= '0;
            period_reg     <= '0;
            pos_reg        <= '0;
            dir_reg        <= 1'b1;
            elapsed_reg    <= '0;
            ms_rem_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsmf_pkg::REG_STEP:
                begin
                    step_reg <= cfg_data[lsmf_pkg::STEP_W-1:0];
                    dir_reg  <= ~cfg_data[lsmf_pkg::STEP_W-1];
                end
                lsmf_pkg::REG_LOW:
                begin
                    range_low_reg <= cfg_data[IDX_W-1:0];
                    pos_reg       <= pos_clamped;
                end
                lsmf_pkg::REG_HIGH:
                begin
                    range_high_reg <= cfg_data[IDX_W-1:0];
                    pos_reg        <= pos_clamped;
                end
                lsmf_pkg::REG_LENGTH:   seg_len_reg  <= cfg_data[IDX_W-1:0];
                lsmf_pkg::REG_MODE:     mode_reg     <= cfg_data[1:0];
                lsmf_pkg::REG_FADE_IN:  fade_in_reg  <= cfg_data;
                lsmf_pkg::REG_FADE_OUT: fade_out_reg <= cfg_data;
                lsmf_pkg::REG_PERIOD:   period_reg   <= cfg_data[MS_W-1:0];
                default:
                begin
                end
            endcase
        end
        else if (cmd.accept)
        begin
            if (func == lsmf_pkg::FUNC_RESTART)
            begin
                pos_reg     <= {lsmf_pkg::sat_idx(start_position), 8'b0};
                elapsed_reg <= '0;
                ms_rem_reg  <= '0;
            end
            else
            begin
                elapsed_reg <= elapsed_next;
                ms_rem_reg  <= ms_rem_next;
            end
        end
        else if (cmd.move_b)
        begin
            dir_reg <= edge_dir;
        end
        else if (cmd.move_c)
        begin
            pos_reg <= clamp_np[POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.move_a)
        begin
            np_reg  <= step_np;
            top_reg <= step_np + len_off;
        end
        else if (cmd.move_b)
        begin
            np_reg <= edge_np;
        end

        if (cmd.phase_start && status.period_zero)
        begin
            phase_reg <= '0;
        end
        else if (cmd.phase_load)
        begin
            phase_reg <= div_rem;
        end

        if (cmd.fade_eval && !fade_active)
        begin
            bright_reg <= lsmf_pkg::BRIGHT_FULL;
        end
        else if (cmd.fade_eval && !fade_div_raw)
        begin
            bright_reg <= fade_const;
        end
        else if (cmd.bright_load)
        begin
            bright_reg <= div_quot[lsmf_pkg::BRIGHT_W-1:0];
        end

        if (cmd.out_load)
        begin
            pos_out_reg    <= pos_reg;
            dir_out_reg    <= dir_reg;
            bright_out_reg <= bright_reg;
            phase_out_reg  <= phase_reg;
        end
    end

    assign position_q8    = pos_out_reg;
    assign moving_up      = dir_out_reg;
    assign brightness_q8  = bright_out_reg;
    assign cycle_phase_ms = phase_out_reg;

endmodule

// File: rtl/led_segment_motion_and_fade.sv
// A frame tick runs move steps A, B and C, then the phase, fade and output steps;
// a fade ramp adds a divider wait and a restart skips the moves. The 48-bit
// elapsed-time modulo in the shared two-bit-per-cycle divider takes most of the
// time. One transaction is in flight at a time; the next can be taken in the cycle
// after the result is registered, even while it waits on out_ready. Reset is
// asynchronous: control, config and motion registers take defaults, direction up.
// ============================================================================
// LED segment motion and fade
// Moves one LED segment by a Q8 step per frame inside a range, with wrap or
// reflect at the edges, and gives a trapezoid fade brightness for the phase
// of a repeating millisecond cycle.
// ============================================================================
`include "assert_macros.svh"

module led_segment_motion_and_fade
#(
    parameter int FRAME_RATE = lsmf_pkg::FRAME_RATE_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsmf_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [lsmf_pkg::IDX_W-1:0]          start_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lsmf_pkg::POS_W-1:0]          position_q8,
    output logic                                moving_up,
    output logic [lsmf_pkg::BRIGHT_W-1:0]       brightness_q8,
    output logic [lsmf_pkg::MS_W-1:0]           cycle_phase_ms
);

    lsmf_pkg::lsmf_cmd_t    cmd;
    lsmf_pkg::lsmf_status_t status;

    lsmf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    lsmf_datapath #(
        .FRAME_RATE (FRAME_RATE)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .start_position (start_position),
        .position_q8    (position_q8),
        .moving_up      (moving_up),
        .brightness_q8  (brightness_q8),
        .cycle_phase_ms (cycle_phase_ms)
    );

    `LSMF_ASSERT_IMP(a_div_start_free, (cmd.phase_start || cmd.fade_eval), !status.div_busy)
    `LSMF_ASSERT_IMP(a_bright_range, out_valid, (brightness_q8 <= lsmf_pkg::BRIGHT_FULL))
    `LSMF_ASSERT_NXT(a_no_accept_div, status.div_busy, !in_ready)

endmodule

// File: tb/led_segment_motion_and_fade_tb.sv
// ============================================================================
// LED segment motion and fade testbench
// Drives frame ticks and restarts through the valid/ready input channel and
// checks every result against a cycle-free predictor of the segment position,
// direction, fade phase and brightness. Configuration is rewritten between
// phases while the block is idle, covering reflect and wrap, swapped and
// narrow ranges, long segments, and the fade ramps and their extremes.
// ============================================================================
module led_segment_motion_and_fade_tb;

    import lsmf_pkg::*;

    localparam int TICKS_PER_S = FRAME_RATE_DEF;

    typedef struct {
        logic            func;
        logic [IDX_W-1:0] start_position;
    } frame_request_t;

    typedef struct {
        logic [POS_W-1:0]    position_q8;
        logic                moving_up;
        logic [BRIGHT_W-1:0] brightness_q8;
        logic [MS_W-1:0]     cycle_phase_ms;
    } frame_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 func = 1'b0;
    logic [IDX_W-1:0]     start_position = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [POS_W-1:0]     position_q8;
    logic                 moving_up;
    logic [BRIGHT_W-1:0]  brightness_q8;
    logic [MS_W-1:0]      cycle_phase_ms;

    frame_request_t frame_requests[$];
    frame_result_t  predicted_frames[$];
    int             mismatches = 0;
    int             results_taken = 0;
    int             hold_left = 0;
    bit             steady = 1'b0;

    // Predictor copy of the configuration and the animation state.
    longint         step_q8;
    logic [IDX_W-1:0] range_lo, range_hi, seg_len;
    logic [1:0]     mode_bits;
    logic [31:0]    fade_in_reg, fade_out_reg;
    logic [MS_W-1:0] period_ms;
    longint         seg_pos;
    bit             dir_up;
    logic [ELAPSED_W-1:0] elapsed_ms;
    int unsigned    ms_sub;

    led_segment_motion_and_fade i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .start_position (start_position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .position_q8    (position_q8),
        .moving_up      (moving_up),
        .brightness_q8  (brightness_q8),
        .cycle_phase_ms (cycle_phase_ms)
    );

    always #5 clk = ~clk;

    function automatic longint clip_led(input logic [IDX_W-1:0] v);
        return (v > MAX_LEDS - 1) ? longint'(MAX_LEDS - 1) : longint'(v);
    endfunction

    function automatic void led_bounds(output longint lo, output longint hi);
        longint a;
        longint b;
        a = clip_led(range_lo);
        b = clip_led(range_hi);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
    endfunction

    function automatic void clamp_position();
        longint lo;
        longint hi;
        led_bounds(lo, hi);
        if (seg_pos < lo * 256)
        begin
            seg_pos = lo * 256;
        end
        else if (seg_pos > hi * 256)
        begin
            seg_pos = hi * 256;
        end
    endfunction

    function automatic logic [BRIGHT_W-1:0] trapezoid_level(input int unsigned t);
        int unsigned in_start;
        int unsigned in_end;
        int unsigned out_start;
        int unsigned out_end;
        in_start  = fade_in_reg[15:0];
        in_end    = fade_in_reg[31:16];
        out_start = fade_out_reg[15:0];
        out_end   = fade_out_reg[31:16];
        if (t < in_start)
        begin
            return BRIGHT_OFF;
        end
        if (t < in_end)
        begin
            return BRIGHT_W'((256 * (t - in_start)) / (in_end - in_start));
        end
        if (t < out_start)
        begin
            return BRIGHT_FULL;
        end
        if (t < out_end)
        begin
            return BRIGHT_W'((256 * (out_end - t)) / (out_end - out_start));
        end
        return BRIGHT_OFF;
    endfunction

    function automatic frame_result_t predict_frame(input logic f,
                                                    input logic [IDX_W-1:0] sp);
        longint        lo;
        longint        hi;
        longint        len;
        longint        mag;
        longint        np;
        longint        top;
        longint        maxp;
        logic [63:0]   phase_wide;
        frame_result_t r;
        led_bounds(lo, hi);
        len = longint'(seg_len);
        if (f == FUNC_RESTART)
        begin
            seg_pos    = clip_led(sp) * 256;
            elapsed_ms = '0;
            ms_sub     = 0;
        end
        else
        begin
            ms_sub     = ms_sub + MS_PER_S;
            elapsed_ms = elapsed_ms + ELAPSED_W'(ms_sub / TICKS_PER_S);
            ms_sub     = ms_sub % TICKS_PER_S;
            mag = (step_q8 < 0) ? -step_q8 : step_q8;
            np  = seg_pos + (dir_up ? mag : -mag);
            top = np + (len - 1) * 256;
            if (mode_bits[0])
            begin
                if (np < lo * 256)
                begin
                    np = 2 * lo * 256 - np;
                    dir_up = 1'b1;
                end
                else if (top > hi * 256)
                begin
                    np = (hi - len + 1) * 256 - (top - hi * 256);
                    dir_up = 1'b0;
                end
            end
            else
            begin
                if (np < lo * 256)
                begin
                    np = hi * 256 + 256 - (lo * 256 - np);
                end
                else if (top > hi * 256)
                begin
                    np = lo * 256 + (top - hi * 256) - 256;
                end
            end
            maxp = (hi - len + 1) * 256;
            if (np > maxp)
            begin
                np = maxp;
            end
            if (np < lo * 256)
            begin
                np = lo * 256;
            end
            seg_pos = np;
        end
        r.position_q8    = seg_pos[POS_W-1:0];
        r.moving_up      = dir_up;
        r.brightness_q8  = BRIGHT_FULL;
        r.cycle_phase_ms = '0;
        if (period_ms != 0)
        begin
            phase_wide = 64'(elapsed_ms) % 64'(period_ms);
            r.cycle_phase_ms = phase_wide[MS_W-1:0];
            if (mode_bits[1])
            begin
                r.brightness_q8 = trapezoid_level(int'(phase_wide[MS_W-1:0]));
            end
        end
        return r;
    endfunction

    task automatic reset_predictor();
        step_q8      = 0;
        range_lo     = '0;
        range_hi     = IDX_W'(1023);
        seg_len      = IDX_W'(1);
        mode_bits    = '0;
        fade_in_reg  = '0;
        fade_out_reg = '0;
        period_ms    = '0;
        seg_pos      = 0;
        dir_up       = 1'b1;
        elapsed_ms   = '0;
        ms_sub       = 0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_STEP:
            begin
                step_q8 = longint'($signed(val[STEP_W-1:0]));
                dir_up  = (step_q8 >= 0);
            end
            REG_LOW:
            begin
                range_lo = val[IDX_W-1:0];
                clamp_position();
            end
            REG_HIGH:
            begin
                range_hi = val[IDX_W-1:0];
                clamp_position();
            end
            REG_LENGTH:   seg_len      = val[IDX_W-1:0];
            REG_MODE:     mode_bits    = val[1:0];
            REG_FADE_IN:  fade_in_reg  = val;
            REG_FADE_OUT: fade_out_reg = val;
            REG_PERIOD:   period_ms    = val[MS_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] step_word(input longint s);
        return 32'(s) & 32'h1FFFF;
    endfunction

    function automatic logic [31:0] fade_word(input int unsigned first, input int unsigned last);
        return {16'(last), 16'(first)};
    endfunction

    task automatic push_request(input logic f, input logic [IDX_W-1:0] sp);
        frame_request_t q;
        q.func = f;
        q.start_position = sp;
        frame_requests.push_back(q);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_request(FUNC_TICK, IDX_W'($urandom_range(0, 1023)));
    endtask

    task automatic wait_until_idle();
        while (frame_requests.size() != 0 || in_valid || predicted_frames.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_random_config();
        longint      s;
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        int unsigned p;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned d;
        case ($urandom_range(0, 5))
            0:       s = 65535;
            1:       s = -65535;
            2:       s = 0;
            3:       s = longint'($urandom_range(0, 3000)) - 1500;
            4:       s = longint'($signed(17'($urandom)));
            default: s = longint'($urandom_range(0, 1200)) - 600;
        endcase
        case ($urandom_range(0, 3))
            0:
            begin
                lo = 0;
                hi = 1023;
            end
            1:
            begin
                lo = $urandom_range(0, 1023);
                hi = $urandom_range(0, 1023);
            end
            2:
            begin
                lo = $urandom_range(0, 900);
                hi = lo + $urandom_range(0, 120);
            end
            default:
            begin
                hi = $urandom_range(0, 900);
                lo = hi + $urandom_range(0, 120);
            end
        endcase
        span = ((lo < hi) ? hi - lo : lo - hi) + 1;
        write_register(REG_STEP, step_word(s));
        write_register(REG_LOW, 32'(lo));
        write_register(REG_HIGH, 32'(hi));
        case ($urandom_range(0, 5))
            0:       write_register(REG_LENGTH, 32'd0);
            1:       write_register(REG_LENGTH, 32'd1023);
            2:       write_register(REG_LENGTH, 32'($urandom_range(1, 32)));
            default: write_register(REG_LENGTH, 32'($urandom_range(1, span + 1)));
        endcase
        write_register(REG_MODE, 32'($urandom_range(0, 3)));
        case ($urandom_range(0, 7))
            0:       p = 0;
            1:       p = 1;
            2:       p = 65535;
            default: p = $urandom_range(100, 1500);
        endcase
        write_register(REG_PERIOD, 32'(p));
        if ($urandom_range(0, 4) == 0)
        begin
            write_register(REG_FADE_IN, $urandom);
            write_register(REG_FADE_OUT, $urandom);
        end
        else
        begin
            a = $urandom_range(0, p / 4);
            b = a + $urandom_range(0, p / 4);
            c = b + $urandom_range(0, p / 4);
            d = c + $urandom_range(0, p / 4);
            write_register(REG_FADE_IN, fade_word(a, b));
            write_register(REG_FADE_OUT, fade_word(c, d));
        end
        end_writes();
    endtask

    // Driver: offers queued requests and predicts each accepted transaction.
    always @(posedge clk)
    begin : driver
        bit             offer;
        frame_request_t nxt;
        if (rst_n)
        begin
            offer = in_valid;
            if (in_valid && in_ready)
            begin
                predicted_frames.push_back(predict_frame(func, start_position));
                offer = 1'b0;
            end
            if (!offer && frame_requests.size() != 0 &&
                (steady || $urandom_range(0, 99) >= 37))
            begin
                nxt = frame_requests.pop_front();
                func           <= nxt.func;
                start_position <= nxt.start_position;
                offer = 1'b1;
            end
            in_valid <= offer;
        end
    end

    // Monitor: checks each accepted result and paces out_ready.
    always @(posedge clk)
    begin : monitor
        frame_result_t want;
        bit            ready_next;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_frames.size() == 0)
                begin
                    $error("result transaction with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = predicted_frames.pop_front();
                    if (position_q8 !== want.position_q8)
                    begin
                        $error("position_q8 expected %0d, got %0d",
                               want.position_q8, position_q8);
                        mismatches++;
                    end
                    if (moving_up !== want.moving_up)
                    begin
                        $error("moving_up expected %0d, got %0d", want.moving_up, moving_up);
                        mismatches++;
                    end
                    if (brightness_q8 !== want.brightness_q8)
                    begin
                        $error("brightness_q8 expected %0d, got %0d",
                               want.brightness_q8, brightness_q8);
                        mismatches++;
                    end
                    if (cycle_phase_ms !== want.cycle_phase_ms)
                    begin
                        $error("cycle_phase_ms expected %0d, got %0d",
                               want.cycle_phase_ms, cycle_phase_ms);
                        mismatches++;
                    end
                end
                results_taken++;
                if (results_taken == 200)
                begin
                    hold_left = 400;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                ready_next = steady || ($urandom_range(0, 99) >= 37);
            end
            out_ready <= ready_next;
        end
    end

    initial
    begin
        #3000000;
        $display("[led_segment_motion_and_fade] ERROR");
        $finish;
    end

    initial
    begin
        reset_predictor();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: full range, zero step.
        push_request(FUNC_RESTART, IDX_W'(0));
        push_ticks(1);
        push_request(FUNC_RESTART, IDX_W'(1023));
        push_ticks(1);
        wait_until_idle();

        // Step of -65535, swapped range, segment longer than the range.
        write_register(REG_STEP, step_word(-65535));
        write_register(REG_LOW, 32'd900);
        write_register(REG_HIGH, 32'd20);
        write_register(REG_LENGTH, 32'd1023);
        end_writes();
        push_ticks(1);
        push_request(FUNC_RESTART, IDX_W'(1023));
        push_ticks(1);
        wait_until_idle();

        // Reflect off the high edge with the fade trapezoid running.
        write_register(REG_STEP, step_word(300));
        write_register(REG_LOW, 32'd10);
        write_register(REG_HIGH, 32'd100);
        write_register(REG_LENGTH, 32'd5);
        write_register(REG_MODE, 32'd3);
        write_register(REG_FADE_IN, fade_word(50, 200));
        write_register(REG_FADE_OUT, fade_word(400, 700));
        write_register(REG_PERIOD, 32'd1000);
        end_writes();
        push_request(FUNC_RESTART, IDX_W'(95));
        push_ticks(2);
        push_request(FUNC_RESTART, IDX_W'(10));
        wait_until_idle();

        // Reflect off the low edge, then a range write that drags the position.
        write_register(REG_STEP, step_word(-300));
        end_writes();
        push_ticks(1);
        wait_until_idle();
        write_register(REG_LOW, 32'd50);
        end_writes();
        push_ticks(1);
        wait_until_idle();

        // Wrap past both edges with the largest steps and a zero length.
        write_register(REG_STEP, step_word(65535));
        write_register(REG_LOW, 32'd0);
        write_register(REG_HIGH, 32'd1023);
        write_register(REG_LENGTH, 32'd0);
        write_register(REG_MODE, 32'd2);
        end_writes();
        push_request(FUNC_RESTART, IDX_W'(1020));
        push_ticks(2);
        wait_until_idle();
        write_register(REG_STEP, step_word(-65535));
        end_writes();
        push_request(FUNC_RESTART, IDX_W'(2));
        push_ticks(1);
        wait_until_idle();

        // Fade times at their maximum, then the longest and shortest cycles.
        write_register(REG_FADE_IN, 32'hFFFF_FFFF);
        write_register(REG_FADE_OUT, 32'hFFFF_FFFF);
        write_register(REG_PERIOD, 32'd65535);
        end_writes();
        push_ticks(2);
        wait_until_idle();
        write_register(REG_PERIOD, 32'd1);
        end_writes();
        push_ticks(2);
        wait_until_idle();

        for (int ph = 0; ph < 13; ph++)
        begin
            set_random_config();
            steady = (ph == 4);
            for (int k = 0; k < 54; k++)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    push_request(FUNC_RESTART, IDX_W'($urandom_range(0, 1023)));
                end
                else
                begin
                    push_ticks(1);
                end
            end
            wait_until_idle();
            steady = 1'b0;
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[led_segment_motion_and_fade] OK");
        end
        else
        begin
            $display("[led_segment_motion_and_fade] ERROR");
        end
        $finish;
    end

endmodule

// File: led_segment_motion_and_fade.f
+incdir+rtl
rtl/lsmf_pkg.sv
rtl/lsmf_div.sv
rtl/lsmf_ctrl.sv
rtl/lsmf_datapath.sv
rtl/led_segment_motion_and_fade.sv
tb/led_segment_motion_and_fade_tb.sv
